>>> src/dgp_pkg.sv
// Shared types, codes and constants of the dynamics gain processor.
`default_nettype none

package dgp_pkg;

    // Mode register codes
    localparam logic [2:0] MODE_COMPRESS = 3'd0;
    localparam logic [2:0] MODE_EXPAND   = 3'd1;
    localparam logic [2:0] MODE_UPWARD   = 3'd2;
    localparam logic [2:0] MODE_UPDOWN   = 3'd3;
    localparam logic [2:0] MODE_LIMIT    = 3'd4;
    localparam logic [2:0] MODE_GATE     = 3'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;

    // Loop lengths of the shared-multiplier sequences
    localparam logic [3:0] POW_LAST = 4'd7;   // eight fraction bits of log2 gain
    localparam logic [3:0] SQ_LAST  = 4'd15;  // sixteen squarings for log2

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_SLOPE,
        OP_TARGET,
        OP_MUL_LOG,
        OP_EXP,
        OP_POW_MUL,
        OP_POW_ACC,
        OP_SCALE,
        OP_MUL_SMOOTH,
        OP_SMOOTH,
        OP_MUL_SAMPLE,
        OP_SAMPLE,
        OP_NORM_INIT,
        OP_NORM_STEP,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_MUL_DB,
        OP_DB,
        OP_BYPASS,
        OP_OUTPUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic ch_ok;
        logic gain_zero;
        logic norm_done;
    } dp_stat_t;

    // 2^(2^-(i+1)) in Q1.30
    function automatic logic [30:0] pow2_frac(input logic [2:0] i);
        logic [30:0] v;
        case (i)
            3'd0:    v = 31'd1518500250;
            3'd1:    v = 31'd1276901417;
            3'd2:    v = 31'd1170923762;
            3'd3:    v = 31'd1121280436;
            3'd4:    v = 31'd1097253708;
            3'd5:    v = 31'd1085434106;
            3'd6:    v = 31'd1079572136;
            3'd7:    v = 31'd1076653033;
            default: v = 31'd1073741824;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/dgp_ctrl.sv
// Sequencing state machine of the dynamics gain processor.
`default_nettype none

module dgp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output dgp_pkg::dp_cmd_t        cmd,
    input  wire dgp_pkg::dp_stat_t  stat
);
    import dgp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TGT_MUL,
        S_BYPASS,
        S_TARGET,
        S_LOG_MUL,
        S_EXP,
        S_POW_MUL,
        S_POW_ACC,
        S_SCALE,
        S_SM_MUL,
        S_SMOOTH,
        S_SMP_MUL,
        S_SAMPLE,
        S_NORM_INIT,
        S_NORM,
        S_SQ_MUL,
        S_SQ_ACC,
        S_DB_MUL,
        S_DB,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.idx        = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_TGT_MUL;
                end
            end
            S_TGT_MUL:
            begin
                cmd.op     = OP_MUL_SLOPE;
                state_next = stat.ch_ok ? S_TARGET : S_BYPASS;
            end
            S_BYPASS:
            begin
                cmd.op     = OP_BYPASS;
                state_next = S_DONE;
            end
            S_TARGET:
            begin
                cmd.op     = OP_TARGET;
                state_next = S_LOG_MUL;
            end
            S_LOG_MUL:
            begin
                cmd.op     = OP_MUL_LOG;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                cmd.op     = OP_EXP;
                cnt_next   = '0;
                state_next = S_POW_MUL;
            end
            S_POW_MUL:
            begin
                cmd.op     = OP_POW_MUL;
                state_next = S_POW_ACC;
            end
            S_POW_ACC:
            begin
                cmd.op = OP_POW_ACC;
                if (cnt_reg == POW_LAST)
                begin
                    state_next = S_SCALE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_POW_MUL;
                end
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_SM_MUL;
            end
            S_SM_MUL:
            begin
                cmd.op     = OP_MUL_SMOOTH;
                state_next = S_SMOOTH;
            end
            S_SMOOTH:
            begin
                cmd.op     = OP_SMOOTH;
                state_next = S_SMP_MUL;
            end
            S_SMP_MUL:
            begin
                cmd.op     = OP_MUL_SAMPLE;
                state_next = S_SAMPLE;
            end
            S_SAMPLE:
            begin
                cmd.op     = OP_SAMPLE;
                state_next = S_NORM_INIT;
            end
            S_NORM_INIT:
            begin
                cmd.op     = OP_NORM_INIT;
                state_next = stat.gain_zero ? S_DONE : S_NORM;
            end
            S_NORM:
            begin
                cmd.op = OP_NORM_STEP;
                if (stat.norm_done)
                begin
                    cnt_next   = '0;
                    state_next = S_SQ_MUL;
                end
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_SQ_MUL;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op = OP_SQ_ACC;
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = S_DB_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_SQ_MUL;
                end
            end
            S_DB_MUL:
            begin
                cmd.op     = OP_MUL_DB;
                state_next = S_DB;
            end
            S_DB:
            begin
                cmd.op     = OP_DB;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_OUTPUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("controller idle right after accepting a word");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result overwritten while output stalled");

endmodule

`default_nettype wire

>>> src/dgp_datapath.sv
// Datapath of the dynamics gain processor: registers, shared multiplier, gain state.
`default_nettype none

module dgp_datapath #(
    parameter int CHANNELS = 2
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [dgp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dgp_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               channel,
    input  wire logic signed [15:0]                 level_db,
    input  wire logic signed [23:0]                 sample_in,
    input  wire dgp_pkg::dp_cmd_t                   cmd,
    output dgp_pkg::dp_stat_t                       stat,
    output logic                                    out_channel,
    output logic signed [23:0]                      sample_out,
    output logic signed [15:0]                      gain_db
);
    import dgp_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic [2:0]         mode_reg;
    logic signed [15:0] threshold_reg;
    logic [15:0]        slope_reg;
    logic [23:0]        attack_reg;
    logic [23:0]        release_reg;

    // per-item working registers
    logic               ch_reg;
    logic signed [23:0] smp_reg;
    logic signed [17:0] delta_reg;
    logic signed [15:0] t_reg;
    logic [4:0]         e_reg;
    logic [7:0]         f_reg;
    logic [31:0]        m_reg;
    logic [31:0]        target_reg;
    logic [31:0]        g_reg;
    logic [31:0]        x_reg;
    logic [4:0]         p_reg;
    logic [15:0]        frac_reg;
    logic signed [23:0] sout_reg;
    logic signed [15:0] gdb_reg;
    logic signed [65:0] prod_reg;

    logic               out_channel_reg;
    logic signed [23:0] sample_out_reg;
    logic signed [15:0] gain_db_reg;

    logic [31:0]        gain_reg [CHANNELS];

    logic signed [32:0] mul_a, mul_b;
    logic               ch_ok;
    logic [CH_W-1:0]    ch_idx;
    logic [31:0]        g_cur;
    logic signed [17:0] clipped;
    logic signed [17:0] neg_delta;
    logic signed [17:0] slope_opnd;
    logic signed [32:0] diff;
    logic [23:0]        coeff;
    logic signed [5:0]  pm21;
    logic signed [21:0] l_val;

    logic signed [65:0] rnd16, ysum, rnd29, rnd24, rnd21, rnd32;
    logic signed [19:0] t_r, t_w;
    logic signed [15:0] t_clamp;
    logic [4:0]         shamt;
    logic [32:0]        sh_l, sh_r;
    logic [33:0]        sh_rnd;
    logic [31:0]        target_next;
    logic [31:0]        g_new;
    logic signed [44:0] s_val;
    logic signed [23:0] s_sat;
    logic [31:0]        sq;
    logic signed [33:0] d_val;
    logic signed [15:0] d_sat;

    assign ch_ok  = (32'(ch_reg) < CHANNELS);
    assign ch_idx = ch_ok ? CH_W'(ch_reg) : '0;
    assign g_cur  = gain_reg[ch_idx];

    assign clipped   = (delta_reg > 18'sd16384) ? 18'sd16384 : delta_reg;
    assign neg_delta = -delta_reg;
    assign diff      = $signed({1'b0, target_reg}) - $signed({1'b0, g_cur});
    assign coeff     = (target_reg < g_cur) ? attack_reg : release_reg;
    assign pm21      = $signed({1'b0, p_reg}) - 6'sd21;
    assign l_val     = {pm21, frac_reg};

    always_comb
    begin
        case (mode_reg)
            MODE_EXPAND: slope_opnd = neg_delta;
            MODE_UPWARD: slope_opnd = clipped;
            MODE_UPDOWN: slope_opnd = clipped;
            default:     slope_opnd = delta_reg;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_SLOPE:
            begin
                mul_a = $signed({17'b0, slope_reg});
                mul_b = $signed({{15{slope_opnd[17]}}, slope_opnd});
            end
            OP_MUL_LOG:
            begin
                mul_a = $signed({{17{t_reg[15]}}, t_reg});
                mul_b = 33'sd174165;
            end
            OP_POW_MUL:
            begin
                mul_a = $signed({1'b0, m_reg});
                mul_b = f_reg[3'd7 - cmd.idx[2:0]] ?
                        $signed({2'b0, pow2_frac(cmd.idx[2:0])}) : 33'sd1073741824;
            end
            OP_MUL_SMOOTH:
            begin
                mul_a = diff;
                mul_b = $signed({9'b0, coeff});
            end
            OP_MUL_SAMPLE:
            begin
                mul_a = $signed({{9{smp_reg[23]}}, smp_reg});
                mul_b = $signed({1'b0, g_reg});
            end
            OP_SQ_MUL:
            begin
                mul_a = $signed({1'b0, x_reg});
                mul_b = $signed({1'b0, x_reg});
            end
            OP_MUL_DB:
            begin
                mul_a = $signed({{11{l_val[21]}}, l_val});
                mul_b = 33'sd50504453;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // target gain in dB by mode, then clamp
    always_comb
    begin
        rnd16 = prod_reg + 66'sd32768;
        t_r   = $signed(rnd16[35:16]);
        t_w   = '0;
        case (mode_reg)
            MODE_COMPRESS: if (delta_reg < 0) t_w = t_r;
            MODE_EXPAND:   if (delta_reg > 0) t_w = t_r;
            MODE_UPWARD:   if (delta_reg > 0) t_w = t_r;
            MODE_UPDOWN:   t_w = t_r;
            MODE_LIMIT:    if (delta_reg < 0) t_w = {{2{delta_reg[17]}}, delta_reg};
            MODE_GATE:     if (delta_reg > 0) t_w = -20'sd16384;
            default:       t_w = '0;
        endcase
        if (t_w < -20'sd24576)
            t_clamp = -16'sd24576;
        else if (t_w > 20'sd16384)
            t_clamp = 16'sd16384;
        else
            t_clamp = t_w[15:0];
    end

    // misc rounding and scaling
    always_comb
    begin
        ysum   = prod_reg + 66'sd4294967296;
        rnd29  = prod_reg + 66'sd536870912;
        rnd24  = prod_reg + 66'sd8388608;
        rnd21  = prod_reg + 66'sd1048576;
        rnd32  = prod_reg + 66'sd2147483648;
        shamt  = 5'd25 - e_reg;
        sh_l   = {m_reg, 1'b0};
        sh_r   = sh_l >> shamt;
        sh_rnd = {1'b0, sh_r} + 34'd1;
        if (e_reg > 5'd25)
            target_next = sh_l[32] ? 32'hFFFF_FFFF : sh_l[31:0];
        else if (e_reg == 5'd25)
            target_next = m_reg;
        else
            target_next = sh_rnd[32:1];
        g_new = g_cur + rnd24[55:24];
        s_val = $signed(rnd21[65:21]);
        if (s_val > 45'sd8388607)
            s_sat = 24'sh7FFFFF;
        else if (s_val < -45'sd8388608)
            s_sat = -24'sh800000;
        else
            s_sat = s_val[23:0];
        sq    = prod_reg[61:30];
        d_val = $signed(rnd32[65:32]);
        if (d_val > 34'sd32767)
            d_sat = 16'sh7FFF;
        else if (d_val < -34'sd32768)
            d_sat = -16'sh8000;
        else
            d_sat = d_val[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_COMPRESS;
            threshold_reg <= 16'sd256;
            slope_reg     <= '0;
            attack_reg    <= 24'hFFFFFF;
            release_reg   <= 24'hFFFFFF;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg      <= cfg_data[2:0];
                REG_THRESHOLD: threshold_reg <= $signed(cfg_data[15:0]);
                REG_SLOPE:     slope_reg     <= cfg_data[15:0];
                REG_ATTACK:    attack_reg    <= cfg_data;
                REG_RELEASE:   release_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
                gain_reg[i] <= '0;
        end
        else if (cmd.op == OP_SMOOTH && ch_ok)
        begin
            gain_reg[ch_idx] <= g_new;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                ch_reg    <= channel;
                smp_reg   <= sample_in;
                delta_reg <= $signed({{2{threshold_reg[15]}}, threshold_reg})
                           - $signed({{2{level_db[15]}}, level_db});
            end
            OP_TARGET:
                t_reg <= t_clamp;
            OP_EXP:
            begin
                e_reg <= ysum[32:28];
                f_reg <= ysum[27:20];
                m_reg <= 32'd1 << 30;
            end
            OP_POW_ACC:
                m_reg <= rnd29[61:30];
            OP_SCALE:
                target_reg <= target_next;
            OP_SMOOTH:
                g_reg <= g_new;
            OP_SAMPLE:
                sout_reg <= s_sat;
            OP_NORM_INIT:
            begin
                x_reg    <= g_reg;
                p_reg    <= 5'd31;
                frac_reg <= '0;
                if (g_reg == '0)
                    gdb_reg <= -16'sh8000;
            end
            OP_NORM_STEP:
            begin
                if (x_reg[31])
                begin
                    x_reg <= x_reg >> 1;
                end
                else
                begin
                    x_reg <= x_reg << 1;
                    p_reg <= p_reg - 5'd1;
                end
            end
            OP_SQ_ACC:
            begin
                if (sq[31])
                begin
                    x_reg <= sq >> 1;
                    frac_reg[4'd15 - cmd.idx] <= 1'b1;
                end
                else
                begin
                    x_reg <= sq;
                end
            end
            OP_DB:
                gdb_reg <= d_sat;
            OP_BYPASS:
            begin
                sout_reg <= '0;
                gdb_reg  <= -16'sh8000;
            end
            OP_OUTPUT:
            begin
                out_channel_reg <= ch_reg;
                sample_out_reg  <= sout_reg;
                gain_db_reg     <= gdb_reg;
            end
            default: ;
        endcase
    end

    assign stat.ch_ok     = ch_ok;
    assign stat.gain_zero = (g_reg == '0);
    assign stat.norm_done = x_reg[31];

    assign out_channel = out_channel_reg;
    assign sample_out  = sample_out_reg;
    assign gain_db     = gain_db_reg;

    a_sq_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SQ_MUL) |-> (x_reg[31:30] == 2'b01))
        else $error("squaring operand not normalized");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SCALE) |-> (e_reg <= 5'd26))
        else $error("gain exponent out of range");

    a_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_POW_MUL) |-> !m_reg[31])
        else $error("gain mantissa overflow");

endmodule

`default_nettype wire

>>> src/dynamics_gain_processor.sv
// Top level of the dynamics gain processor.
`default_nettype none

// Dynamics gain processor. Each input word carries a channel number, that
// channel's RMS level in dB (Q7.8) and one Q0.23 sample. The block forms a
// target gain by mode (compress, expand, upward, up/down, limit, gate),
// converts it to linear Q11.21, smooths it per channel with the attack or
// release coefficient and returns the scaled, saturated sample together with
// the smoothed gain in dB. Items are handled one at a time by a sequencer
// driving a single shared 33x33 multiplier. The time an item takes grows with
// the leading zero count of the smoothed gain; a zero gain or an out-of-range
// channel finishes early. After each item the sequencer returns to idle before
// the next word is taken. The dominant costs are the eight-step exponent
// product and the sixteen squarings of the log stage, both on that multiplier,
// and the leading-one search. A finished word waits in the output register
// while the next is accepted. Configuration is to be written only while the
// block is idle; the user is bound by this and the block does not enforce it.

module dynamics_gain_processor #(
    parameter int CHANNELS = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_write,
    input  wire logic [dgp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dgp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic                            channel,
    input  wire logic signed [15:0]              level_db,
    input  wire logic signed [23:0]              sample_in,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 out_channel,
    output logic signed [23:0]                   sample_out,
    output logic signed [15:0]                   gain_db
);
    import dgp_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence the work of one word and own both handshakes
    dgp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold configuration, per-channel gain and the arithmetic
    dgp_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .channel     (channel),
        .level_db    (level_db),
        .sample_in   (sample_in),
        .cmd         (cmd),
        .stat        (stat),
        .out_channel (out_channel),
        .sample_out  (sample_out),
        .gain_db     (gain_db)
    );

endmodule

`default_nettype wire

>>> tb/dynamics_gain_processor_tb.sv
// Self-checking testbench for the dynamics gain processor: gain predictor and result scoreboard.
`default_nettype none

module dynamics_gain_processor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dgp_pkg::*;

    // Expected output word of one accepted input word
    typedef struct {
        logic              chan;
        logic signed [23:0] smp;
        logic signed [15:0] gdb;
    } gain_result_t;

    // Predicts the block: holds its own copy of the registers and of the smoothed
    // gain per channel, queues expected words and checks arriving ones in order.
    class gain_scoreboard;
        logic [2:0]         mode;
        logic signed [15:0] thr;
        logic [15:0]        slope;
        logic [23:0]        atk;
        logic [23:0]        rel;
        logic [31:0]        held_gain [2];
        gain_result_t       expected_q [$];
        int                 errors;

        function new();
            mode = MODE_COMPRESS;
            thr = 16'sd256;
            slope = '0;
            atk = 24'hFFFFFF;
            rel = 24'hFFFFFF;
            held_gain[0] = '0;
            held_gain[1] = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_MODE:      mode = d[2:0];
                REG_THRESHOLD: thr = d[15:0];
                REG_SLOPE:     slope = d[15:0];
                REG_ATTACK:    atk = d;
                REG_RELEASE:   rel = d;
                default: ;
            endcase
        endfunction

        // round half up by an arithmetic shift
        static function longint round_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        // dB (Q7.8) to linear gain Q11.21
        static function logic [31:0] to_linear(longint t);
            longint unsigned frac [8];
            longint y;
            longint unsigned m;
            int e, f, s;
            frac = '{64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
                     64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033};
            y = t * 174165 + (longint'(16) << 28);
            e = int'(y >> 28);
            f = int'((y >> 20) & 255);
            m = 64'd1 << 30;
            for (int i = 0; i < 8; i++)
                if (f & (8'h80 >> i))
                    m = (m * frac[i] + (64'd1 << 29)) >> 30;
            s = 25 - e;
            if (s < 0)
                m = m << (-s);
            else if (s > 0)
                m = (m + (64'd1 << (s - 1))) >> s;
            if (m > 64'hFFFF_FFFF)
                m = 64'hFFFF_FFFF;
            return m[31:0];
        endfunction

        // linear gain to 10*log10 in Q7.8, rounded
        static function logic [15:0] to_db(logic [31:0] g);
            int p;
            longint unsigned x;
            longint l, d;
            if (g == 0)
                return 16'h8000;
            p = 31;
            while (!g[p])
                p--;
            x = (p <= 30) ? (longint'(g) << (30 - p)) : (longint'(g) >> 1);
            l = longint'(p - 21) * 65536;
            for (int i = 0; i < 16; i++)
            begin
                x = (x * x) >> 30;
                if (x >= (64'd2 << 30))
                begin
                    x = x >> 1;
                    l += longint'(1) << (15 - i);
                end
            end
            d = round_shift(l * 50504453, 32);
            if (d < -32768) d = -32768;
            if (d > 32767) d = 32767;
            return d[15:0];
        endfunction

        function void note_input(logic ch, logic signed [15:0] lvl, logic signed [23:0] smp);
            longint level, th, delta, clipped, t, s;
            logic [31:0] target, g, c;
            gain_result_t r;
            level = lvl;
            th = thr;
            delta = th - level;
            clipped = (delta > 16384) ? 16384 : delta;
            t = 0;
            case (mode)
                MODE_COMPRESS: if (level > th) t = round_shift(longint'(slope) * delta, 16);
                MODE_EXPAND:   if (level < th) t = round_shift(longint'(slope) * (-delta), 16);
                MODE_UPWARD:   if (level < th) t = round_shift(longint'(slope) * clipped, 16);
                MODE_UPDOWN:   t = round_shift(longint'(slope) * clipped, 16);
                MODE_LIMIT:    if (level > th) t = delta;
                MODE_GATE:     if (level < th) t = -16384;
                default:       t = 0;
            endcase
            if (t < -24576) t = -24576;
            if (t > 16384) t = 16384;
            target = to_linear(t);
            g = held_gain[ch];
            c = (target < g) ? {8'd0, atk} : {8'd0, rel};
            g = g + 32'(round_shift((longint'(target) - longint'(g)) * longint'(c), 24));
            held_gain[ch] = g;
            s = round_shift(longint'(smp) * longint'(g), 21);
            if (s > 8388607) s = 8388607;
            if (s < -8388608) s = -8388608;
            r.chan = ch;
            r.smp = s[23:0];
            r.gdb = to_db(g);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic ch, logic signed [23:0] smp, logic signed [15:0] gdb);
            gain_result_t r;
            if (expected_q.size() == 0)
            begin
                $error("unexpected output word: out_channel=%0d sample_out=%0d gain_db=%0d",
                       ch, smp, gdb);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (ch !== r.chan)
            begin
                $error("out_channel: expected %0d, actual %0d", r.chan, ch);
                errors++;
            end
            if (smp !== r.smp)
            begin
                $error("sample_out: expected %0d, actual %0d", r.smp, smp);
                errors++;
            end
            if (gdb !== r.gdb)
            begin
                $error("gain_db: expected %0d, actual %0d", r.gdb, gdb);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   channel = 1'b0;
    logic signed [15:0]     level_db = '0;
    logic signed [23:0]     sample_in = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   out_channel;
    logic signed [23:0]     sample_out;
    logic signed [15:0]     gain_db;

    gain_scoreboard gain_sb = new();

    dynamics_gain_processor #(.CHANNELS(2)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .channel(channel), .level_db(level_db), .sample_in(sample_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_channel(out_channel), .sample_out(sample_out), .gain_db(gain_db)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Write one register; call right after a rising edge, returns right after one.
    // The write enable stays high so that writes can follow back to back; the
    // caller drops it after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        gain_sb.write_reg(idx, d);
        @(posedge clk);
    endtask

    // Present one word and hold it until the block takes it. Valid is left high
    // so that a following word in the same burst goes out back to back.
    task automatic send_word(logic ch, logic signed [15:0] lvl, logic signed [23:0] smp);
        in_valid <= 1'b1;
        channel <= ch;
        level_db <= lvl;
        sample_in <= smp;
        do
            @(posedge clk);
        while (in_stall);
        gain_sb.note_input(ch, lvl, smp);
    endtask

    // Drop valid for a number of cycles.
    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drain every expected word, then let the sequencer settle before a write.
    task automatic drain_outputs();
        idle_sender(1);
        while (gain_sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic load_setting(logic [2:0] md, logic [15:0] th, logic [15:0] sl,
                                logic [23:0] at, logic [23:0] rl);
        drain_outputs();
        write_reg(REG_MODE, {21'd0, md});
        write_reg(REG_THRESHOLD, {8'd0, th});
        write_reg(REG_SLOPE, {8'd0, sl});
        write_reg(REG_ATTACK, at);
        write_reg(REG_RELEASE, rl);
        cfg_write <= 1'b0;
    endtask

    // Level mostly near the threshold so every mode sees both sides of it;
    // sometimes anywhere in range.
    function automatic logic signed [15:0] pick_level();
        int v;
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        v = int'(gain_sb.thr) + $signed($urandom_range(0, 12000)) - 6000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Receiver: check every accepted word and stall on a pattern whose rate is
    // redrawn at random, including stretches with no stall.
    int stall_rate = 0;
    int stall_cnt = 0;
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            gain_sb.check_result(out_channel, sample_out, gain_db);
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 300 == 0)
            stall_rate <= $urandom_range(0, 3);
        case (stall_rate)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            2: out_stall <= ($urandom_range(0, 9) < 8);
            default: out_stall <= (stall_cnt % 16) < 5;
        endcase
    end

    initial
    begin
        logic [2:0] md;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, then each mode with extreme words.
        send_word(1'b0, 16'sh7FFF, 24'sh7FFFFF);
        send_word(1'b1, 16'sh8000, 24'sh800000);
        for (int m = 0; m < 8; m++)
        begin
            load_setting(3'(m), 16'sd0, 16'hFFFF, 24'hFFFFFF, 24'h800000);
            send_word(1'b0, 16'sh7FFF, 24'sh7FFFFF);
            send_word(1'b0, 16'sh8000, 24'sh800000);
            send_word(1'b1, 16'sd0, 24'sd1);
        end
        // Zero coefficients hold the gain; extreme threshold and zero slope.
        load_setting(MODE_UPDOWN, 16'h8000, 16'h0000, 24'h000000, 24'h000000);
        send_word(1'b0, 16'sd0, 24'sh400000);
        load_setting(MODE_LIMIT, 16'h7FFF, 16'hFFFF, 24'h000001, 24'hFFFFFF);
        send_word(1'b1, 16'sh8000, 24'sh7FFFFF);

        // Random phases with new settings; extremes show up in some of them.
        for (int ph = 0; ph < 12; ph++)
        begin
            md = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
            load_setting(md,
                         (ph % 4 == 1) ? 16'h8000 : (ph % 4 == 2) ? 16'h7FFF : 16'($urandom),
                         (ph == 3) ? 16'h0000 : (ph == 5) ? 16'hFFFF : 16'($urandom),
                         (ph == 6) ? 24'h0 : (ph == 7) ? 24'hFFFFFF : 24'($urandom),
                         (ph == 9) ? 24'h0 : (ph == 10) ? 24'hFFFFFF : 24'($urandom));
            for (int n = 0; n < 170; )
            begin
                for (int b = $urandom_range(1, 12); b > 0 && n < 170; b--, n++)
                    send_word(1'($urandom), pick_level(), 24'($urandom));
                if (n == 85 && ph == 4)
                    drain_outputs();
                else if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 150));
            end
        end

        drain_outputs();
        if (gain_sb.errors == 0 && gain_sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
